// File: rtl/swfcc_pkg.sv
// shared types, constants and functions of the sync word frame crc checker
package swfcc_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int SYNC_BYTES      = 4;
    localparam int LEN_W           = 7;
    localparam int CMD_FIFO_DEPTH  = 2;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [31:0] SYNC_PATTERN_RST   = 32'hAABBCCDD;
    localparam logic [6:0]  PAYLOAD_LENGTH_RST = 7'd64;

    // configuration register indexes
    localparam logic [0:0] CFG_SYNC_PATTERN   = 1'b0;
    localparam logic [0:0] CFG_PAYLOAD_LENGTH = 1'b1;

    // command handed from the front end to the emitter
    typedef struct packed {
        logic             err;
        logic             bank;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // emitter tells the front end that a payload bank is free again
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_DRAIN
    } bk_state_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] sync_byte(input logic [31:0] pat, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = pat[31:24];
            2'd1:    b = pat[23:16];
            2'd2:    b = pat[15:8];
            default: b = pat[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: rtl/swfcc_cmd_fifo.sv
// two-entry command queue between the front end and the emitter
module swfcc_cmd_fifo
    import swfcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/swfcc_front.sv
// front end: config registers, sync hunt, payload capture, crc check
module swfcc_front
    import swfcc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              wr_en,
    output logic              wr_bank,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              fifo_full,
    input  rel_t              rel
);

    logic [31:0]      sync_pattern_reg;
    logic [LEN_W-1:0] payload_length_reg;
    logic [LEN_W-1:0] fp_reg, fp_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
    logic             hunt, is_store, is_hi, is_lo;
    logic             accept, crc_ok;

    always_comb begin
        if (payload_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (payload_length_reg > LEN_W'(MAX_PAYLOAD)) begin
            len = LEN_W'(MAX_PAYLOAD);
        end else begin
            len = payload_length_reg;
        end
    end

    assign hunt     = (fp_reg < LEN_W'(SYNC_BYTES));
    assign pos      = fp_reg - LEN_W'(SYNC_BYTES);
    assign is_store = !hunt && (pos < len);
    assign is_hi    = !hunt && (pos == len);
    assign is_lo    = !hunt && (pos > len);

    // hold off while the target bank still drains or the queue has no room
    assign s_ready = !(is_store && busy_reg[wbank_reg]) && !(is_lo && fifo_full);
    assign accept  = s_valid && s_ready;
    assign crc_ok  = ({crc_hi_reg, s_rx_byte} == crc_reg);

    assign wr_en        = accept && is_store;
    assign wr_bank      = wbank_reg;
    assign wr_addr      = pos[ADDR_W-1:0];
    assign wr_data      = s_rx_byte;
    assign push         = accept && is_lo;
    assign push_cmd.err  = !crc_ok;
    assign push_cmd.bank = wbank_reg;
    assign push_cmd.len  = len;

    always_comb begin
        fp_next     = fp_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        wbank_next  = wbank_reg;
        busy_next   = busy_reg;
        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept) begin
            if (hunt) begin
                if (s_rx_byte == sync_byte(sync_pattern_reg, fp_reg[1:0])) begin
                    fp_next = fp_reg + 1'b1;
                    if (fp_reg == LEN_W'(SYNC_BYTES - 1)) begin
                        crc_next = CRC_INIT;
                    end
                end else begin
                    // retry the byte as the first sync byte
                    fp_next = (s_rx_byte == sync_byte(sync_pattern_reg, 2'd0)) ?
                              LEN_W'(1) : '0;
                end
            end else if (is_store) begin
                crc_next = crc_fold(crc_reg, s_rx_byte);
                fp_next  = fp_reg + 1'b1;
            end else if (is_hi) begin
                crc_hi_next = s_rx_byte;
                fp_next     = fp_reg + 1'b1;
            end else begin
                fp_next = '0;
                if (crc_ok) begin
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_pattern_reg   <= SYNC_PATTERN_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
            fp_reg             <= '0;
            crc_reg            <= CRC_INIT;
            crc_hi_reg         <= '0;
            wbank_reg          <= 1'b0;
            busy_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SYNC_PATTERN:   sync_pattern_reg   <= cfg_data;
                    CFG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            fp_reg     <= fp_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            wbank_reg  <= wbank_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

// File: rtl/swfcc_back.sv
// emitter: two-bank payload memory, drain sequencer and output register
module swfcc_back
    import swfcc_pkg::*;
#(
    parameter int ADDR_W      = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic              wr_bank,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  cmd_t              head,
    input  logic              empty,
    output logic              pop,
    output rel_t              rel,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_payload_byte,
    output logic              m_frame_last,
    output logic              m_crc_error
);

    localparam int DEPTH = 2 * (1 << ADDR_W);

    logic [7:0]       mem [DEPTH];

    bk_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic             st_valid_reg, st_err_reg, st_last_reg;
    logic [7:0]       rd_data_reg;
    logic             m_valid_reg, m_frame_last_reg, m_crc_error_reg;
    logic [7:0]       m_payload_byte_reg;

    logic             st_load, can_issue, issue_rd, issue_err, last_rd;

    assign st_load   = st_valid_reg && (!m_valid_reg || m_ready);
    assign can_issue = !st_valid_reg || st_load;
    assign last_rd   = ({{(LEN_W - ADDR_W){1'b0}}, cnt_reg} == len_reg - 1'b1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!empty && can_issue && !head.err) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (can_issue && last_rd) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        issue_rd  = 1'b0;
        issue_err = 1'b0;
        rel       = '0;
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        len_next  = len_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!empty && can_issue) begin
                    pop = 1'b1;
                    if (head.err) begin
                        issue_err = 1'b1;
                    end else begin
                        cnt_next  = '0;
                        bank_next = head.bank;
                        len_next  = head.len;
                    end
                end
            end
            BK_DRAIN: begin
                if (can_issue) begin
                    issue_rd = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (last_rd) begin
                        rel.en   = 1'b1;
                        rel.bank = bank_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{wr_bank, wr_addr}] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_rd) begin
            rd_data_reg <= mem[{bank_reg, cnt_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (issue_rd || issue_err) begin
                st_valid_reg <= 1'b1;
            end else if (st_load) begin
                st_valid_reg <= 1'b0;
            end
            if (st_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        bank_reg <= bank_next;
        len_reg  <= len_next;
        if (issue_rd || issue_err) begin
            st_err_reg  <= issue_err;
            st_last_reg <= issue_err || last_rd;
        end
        if (st_load) begin
            m_payload_byte_reg <= st_err_reg ? 8'h00 : rd_data_reg;
            m_frame_last_reg   <= st_last_reg;
            m_crc_error_reg    <= st_err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = m_payload_byte_reg;
    assign m_frame_last   = m_frame_last_reg;
    assign m_crc_error    = m_crc_error_reg;

endmodule

// File: rtl/sync_word_frame_crc_checker_top.sv
// top level of the sync word frame crc checker
//
// Input channel s_*: one received byte per transaction. The block hunts for the
// 4-byte sync word, captures payload_length payload bytes while folding them into
// a crc-16 (poly 0x1021, start 0xffff), then takes a big-endian 2-byte crc.
// Output channel m_*: on a crc match, one transaction per payload byte with
// m_frame_last on the final one; on a mismatch, one transaction with m_crc_error
// and m_frame_last set and a zero byte.
// Throughput: one input byte per cycle. The front end stalls s_ready only when a
// payload byte targets a memory bank that is still being drained, or when the
// two-entry command queue is full at the crc low byte.
// With an idle emitter an error transaction goes from the command queue through
// the read stage to the output register; a good frame then drains at one byte
// per cycle from a registered memory read while m_ready does not stall.
// Two payload banks let a frame drain while the next one is received.
// Reset (aresetn low, synchronous) restores the register defaults and returns to
// the hunt; no clearing pass is needed. A stalled m_ready holds the output
// register; the read stage holds one more result and the queue up to two frames.
module sync_word_frame_crc_checker_top
    import swfcc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_last,
    output logic        m_crc_error
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              wr_en, wr_bank;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              push, pop, fifo_full, fifo_empty;
    cmd_t              push_cmd, head;
    rel_t              rel;

    swfcc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .fifo_full (fifo_full),
        .rel       (rel)
    );

    swfcc_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    swfcc_back #(
        .ADDR_W      (ADDR_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr_en          (wr_en),
        .wr_bank        (wr_bank),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .head           (head),
        .empty          (fifo_empty),
        .pop            (pop),
        .rel            (rel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_last   (m_frame_last),
        .m_crc_error    (m_crc_error)
    );

    // the front end never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !fifo_full)
        else $error("command pushed into full queue");

    // the emitter never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !fifo_empty)
        else $error("command popped from empty queue");

    // an error transaction is a one-item frame with a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_crc_error) |-> (m_frame_last && m_payload_byte == 8'h00))
        else $error("malformed crc error transaction");

    // a payload write never lands in the bank being released in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rel.en) |-> (wr_bank != rel.bank))
        else $error("payload write into a bank still draining");

endmodule
